>>> src/bdhd_pkg.sv
`default_nettype none

package bdhd_pkg;

	localparam int TICK_W     = 32;
	localparam int DELAY_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MODE_W     = 3;
	localparam int CODE_W     = 2;

	localparam int TICKS_PER_SEC = 1000;

	localparam logic [DELAY_W-1:0] DEBOUNCE_RST = DELAY_W'(TICKS_PER_SEC / 20);
	localparam logic [DELAY_W-1:0] RELEASE_RST  = DELAY_W'(TICKS_PER_SEC / 50);
	localparam logic [DELAY_W-1:0] HOLD_RST     = DELAY_W'(TICKS_PER_SEC / 2);

	// trigger modes
	localparam logic [MODE_W-1:0] MODE_PRESS    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HOLD     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_REL_HOLD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_HOLD_REL = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ALL      = 3'd5;
	localparam logic [MODE_W-1:0] MODE_RST      = MODE_PRESS;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS     = 2'd3;

	// reported button_state codes
	localparam logic [CODE_W-1:0] CODE_RELEASED = 2'd0;
	localparam logic [CODE_W-1:0] CODE_PRESSED  = 2'd1;
	localparam logic [CODE_W-1:0] CODE_HELD     = 2'd2;

	typedef enum logic [2:0] {
		BS_RELEASED = 3'b001,
		BS_PRESSED  = 3'b010,
		BS_HELD     = 3'b100
	} btn_state_t;

	typedef enum logic [2:0] {
		PH_NONE    = 3'b001,
		PH_PRESS   = 3'b010,
		PH_RELEASE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [MODE_W-1:0]  trigger_mode;
		logic [DELAY_W-1:0] debounce_ticks;
		logic [DELAY_W-1:0] release_ticks;
		logic [DELAY_W-1:0] hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic              press_event;
		logic              hold_event;
		logic [CODE_W-1:0] button_state;
	} res_t;

endpackage

`default_nettype wire

>>> src/bdhd_in_if.sv
`default_nettype none

interface bdhd_in_if;
	logic                      valid;
	logic                      ready;
	logic                      pin_active;
	logic [bdhd_pkg::TICK_W-1:0] now_tick;

	modport source (output valid, output pin_active, output now_tick, input ready);
	modport sink   (input valid, input pin_active, input now_tick, output ready);
endinterface

`default_nettype wire

>>> src/bdhd_out_if.sv
`default_nettype none

interface bdhd_out_if;
	logic                        valid;
	logic                        ready;
	logic                        press_event;
	logic                        hold_event;
	logic [bdhd_pkg::CODE_W-1:0] button_state;

	modport source (output valid, output press_event, output hold_event,
		output button_state, input ready);
	modport sink   (input valid, input press_event, input hold_event,
		input button_state, output ready);
endinterface

`default_nettype wire

>>> src/button_debounce_hold_detector.sv
// A word accepted into the input register moves on to the output register when that
// register is free or being drained.
// Throughput: one word per cycle while the sink keeps taking results; the state update
// for a poll is combinational between the input register and the output register.
// Reset (arst_n low, asynchronous): pipeline empty, button released, nothing pending,
// start times zero, registers at mode 0 and delays 50 / 20 / 500 ticks.
`default_nettype none

module button_debounce_hold_detector #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	bdhd_in_if.sink                               in_ch,
	bdhd_out_if.source                            out_ch,
	input  wire logic                             cfg_wen,
	input  wire logic [bdhd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [bdhd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bdhd_pkg::cfg_t cfg;
	bdhd_pkg::res_t step_res;
	bdhd_pkg::res_t out_q;

	// input register: one poll word waiting for the step logic
	logic                          valid_s1;
	logic                          pin_s1;
	logic [bdhd_pkg::TICK_W-1:0]   now_s1;

	logic out_valid_q;
	logic advance;
	logic in_ready;

	// Advance the held poll when the output register is free or being drained.
	// The button state is updated in the same cycle, so the next poll sees it.
	assign advance  = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ready = !valid_s1 || advance;
	assign in_ch.ready = in_ready;

	bdhd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	bdhd_step #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.pin_active (pin_s1),
		.now_tick   (now_s1),
		.cfg        (cfg),
		.res        (step_res)
	);

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// input payload: load on every accepted word
	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			pin_s1 <= in_ch.pin_active;
			now_s1 <= in_ch.now_tick;
		end
	end

	// output register: hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.press_event  = out_q.press_event;
	assign out_ch.hold_event   = out_q.hold_event;
	assign out_ch.button_state = out_q.button_state;

endmodule

`default_nettype wire

>>> src/bdhd_cfg.sv
`default_nettype none

module bdhd_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wen,
	input  wire logic [bdhd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [bdhd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output bdhd_pkg::cfg_t                         cfg
);

	bdhd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_mode   <= bdhd_pkg::MODE_RST;
			cfg_q.debounce_ticks <= bdhd_pkg::DEBOUNCE_RST;
			cfg_q.release_ticks  <= bdhd_pkg::RELEASE_RST;
			cfg_q.hold_ticks     <= bdhd_pkg::HOLD_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				bdhd_pkg::REG_TRIGGER_MODE: begin
					cfg_q.trigger_mode <= cfg_data[bdhd_pkg::MODE_W-1:0];
				end
				bdhd_pkg::REG_DEBOUNCE_TICKS: begin
					cfg_q.debounce_ticks <= cfg_data[bdhd_pkg::DELAY_W-1:0];
				end
				bdhd_pkg::REG_RELEASE_TICKS: begin
					cfg_q.release_ticks <= cfg_data[bdhd_pkg::DELAY_W-1:0];
				end
				bdhd_pkg::REG_HOLD_TICKS: begin
					cfg_q.hold_ticks <= cfg_data[bdhd_pkg::DELAY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> src/bdhd_step.sv
`default_nettype none

module bdhd_step #(
	parameter int TIME_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step_en,
	input  wire logic                          pin_active,
	input  wire logic [bdhd_pkg::TICK_W-1:0]   now_tick,
	input  wire bdhd_pkg::cfg_t                cfg,
	output bdhd_pkg::res_t                     res
);

	// compare width: elapsed time and delays both fit
	localparam int CMP_W = (TIME_WIDTH > bdhd_pkg::DELAY_W) ? TIME_WIDTH : bdhd_pkg::DELAY_W;
	localparam int EXT_W = (TIME_WIDTH > bdhd_pkg::TICK_W) ? TIME_WIDTH : bdhd_pkg::TICK_W;

	bdhd_pkg::btn_state_t  state_q, state_d;
	bdhd_pkg::phase_t      phase_q, phase_d;
	logic [TIME_WIDTH-1:0] press_start_q, press_start_d;
	logic [TIME_WIDTH-1:0] rel_start_q, rel_start_d;

	logic [EXT_W-1:0]      now_ext;
	logic [TIME_WIDTH-1:0] now_t;
	logic [TIME_WIDTH-1:0] press_el;
	logic [TIME_WIDTH-1:0] rel_el;
	logic                  press_gt_db;
	logic                  press_gt_hold;
	logic                  rel_gt_rel;
	logic                  hold_mode;
	logic                  press_ev;
	logic                  hold_ev;

	// elapsed times wrap modulo 2^TIME_WIDTH
	assign now_ext  = EXT_W'(now_tick);
	assign now_t    = now_ext[TIME_WIDTH-1:0];
	assign press_el = now_t - press_start_q;
	assign rel_el   = now_t - rel_start_q;

	assign press_gt_db   = CMP_W'(press_el) > CMP_W'(cfg.debounce_ticks);
	assign press_gt_hold = CMP_W'(press_el) > CMP_W'(cfg.hold_ticks);
	assign rel_gt_rel    = CMP_W'(rel_el) > CMP_W'(cfg.release_ticks);

	assign hold_mode = cfg.trigger_mode inside {bdhd_pkg::MODE_HOLD, bdhd_pkg::MODE_REL_HOLD,
		bdhd_pkg::MODE_HOLD_REL, bdhd_pkg::MODE_ALL};

	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		press_start_d = press_start_q;
		rel_start_d   = rel_start_q;
		press_ev      = 1'b0;
		hold_ev       = 1'b0;
		if (pin_active) begin
			case (state_q)
				bdhd_pkg::BS_RELEASED: begin
					if (phase_q == bdhd_pkg::PH_PRESS) begin
						if (press_gt_db) begin
							state_d  = bdhd_pkg::BS_PRESSED;
							phase_d  = bdhd_pkg::PH_NONE;
							press_ev = (cfg.trigger_mode == bdhd_pkg::MODE_PRESS);
						end
					end else begin
						phase_d       = bdhd_pkg::PH_PRESS;
						press_start_d = now_t;
					end
				end
				bdhd_pkg::BS_PRESSED: begin
					if (hold_mode && press_gt_hold) begin
						state_d = bdhd_pkg::BS_HELD;
						hold_ev = cfg.trigger_mode inside
							{bdhd_pkg::MODE_HOLD, bdhd_pkg::MODE_REL_HOLD};
					end
				end
				default: begin
				end
			endcase
		end else if (state_q != bdhd_pkg::BS_RELEASED) begin
			if (phase_q == bdhd_pkg::PH_RELEASE) begin
				if (rel_gt_rel) begin
					if (state_q == bdhd_pkg::BS_PRESSED) begin
						press_ev = cfg.trigger_mode inside {bdhd_pkg::MODE_RELEASE,
							bdhd_pkg::MODE_REL_HOLD, bdhd_pkg::MODE_ALL};
					end else begin
						hold_ev = cfg.trigger_mode inside
							{bdhd_pkg::MODE_HOLD_REL, bdhd_pkg::MODE_ALL};
					end
					state_d = bdhd_pkg::BS_RELEASED;
					phase_d = bdhd_pkg::PH_NONE;
				end
			end else begin
				phase_d     = bdhd_pkg::PH_RELEASE;
				rel_start_d = now_t;
			end
		end else if (phase_q == bdhd_pkg::PH_PRESS) begin
			phase_d = bdhd_pkg::PH_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bdhd_pkg::BS_RELEASED;
			phase_q       <= bdhd_pkg::PH_NONE;
			press_start_q <= '0;
			rel_start_q   <= '0;
		end else if (step_en) begin
			state_q       <= state_d;
			phase_q       <= phase_d;
			press_start_q <= press_start_d;
			rel_start_q   <= rel_start_d;
		end
	end

	always_comb begin
		res.press_event = press_ev;
		res.hold_event  = hold_ev;
		case (state_d)
			bdhd_pkg::BS_PRESSED: res.button_state = bdhd_pkg::CODE_PRESSED;
			bdhd_pkg::BS_HELD:    res.button_state = bdhd_pkg::CODE_HELD;
			default:              res.button_state = bdhd_pkg::CODE_RELEASED;
		endcase
	end

endmodule

`default_nettype wire

>>> src/bdhd_checker.sv
`default_nettype none

module bdhd_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic                           press_event,
	input wire logic                           hold_event,
	input wire logic [bdhd_pkg::CODE_W-1:0]    button_state
);

	// a single poll never fires both events
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(press_event && hold_event))
		else $error("press and hold events in the same word");

	// reported state is one of released, pressed, held
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (button_state == bdhd_pkg::CODE_RELEASED ||
			button_state == bdhd_pkg::CODE_PRESSED ||
			button_state == bdhd_pkg::CODE_HELD))
		else $error("illegal button_state code");

	// a hold event comes with entry to held or release from held, never while pressed
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hold_event) |-> (button_state != bdhd_pkg::CODE_PRESSED))
		else $error("hold event while pressed");

	// a press event comes with entry to pressed or release from pressed
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && press_event) |-> (button_state != bdhd_pkg::CODE_HELD))
		else $error("press event while held");

	// a stalled result word keeps its state
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(button_state)))
		else $error("stalled result word changed");

endmodule

bind button_debounce_hold_detector bdhd_checker u_bdhd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.press_event  (out_ch.press_event),
	.hold_event   (out_ch.hold_event),
	.button_state (out_ch.button_state)
);

`default_nettype wire

>>> bench/debounce_checker.sv
`default_nettype none

module debounce_checker
	import bdhd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic                  in_pin,
	input  wire logic [TICK_W-1:0]     in_tick,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic                  out_press,
	input  wire logic                  out_hold,
	input  wire logic [CODE_W-1:0]     out_state,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fails,
	output int                         outstanding
);

	localparam int REPORT_MAX = 10;

	logic [MODE_W-1:0]  mode;
	logic [DELAY_W-1:0] press_delay;
	logic [DELAY_W-1:0] release_delay;
	logic [DELAY_W-1:0] hold_delay;

	btn_state_t        btn;
	phase_t            phase;
	logic [TICK_W-1:0] press_t0;
	logic [TICK_W-1:0] release_t0;

	res_t expected_results[$];
	res_t seen_word;
	res_t want_word;
	int   mismatch_count;

	assign fails = mismatch_count;

	// Advance the button model by one poll and return the word it should produce.
	function automatic res_t debounce_poll(input logic pin, input logic [TICK_W-1:0] now);
		res_t              word;
		logic              hold_capable;
		logic [TICK_W-1:0] since_press;
		logic [TICK_W-1:0] since_release;
		word = '0;
		hold_capable = (mode == MODE_HOLD) || (mode == MODE_REL_HOLD) ||
			(mode == MODE_HOLD_REL) || (mode == MODE_ALL);
		since_press   = now - press_t0;
		since_release = now - release_t0;
		if (pin) begin
			if (btn == BS_RELEASED) begin
				if (phase == PH_PRESS) begin
					if (since_press > press_delay) begin
						btn   = BS_PRESSED;
						phase = PH_NONE;
						word.press_event = (mode == MODE_PRESS);
					end
				end else begin
					phase    = PH_PRESS;
					press_t0 = now;
				end
			end else if (btn == BS_PRESSED && hold_capable && since_press > hold_delay) begin
				btn = BS_HELD;
				word.hold_event = (mode == MODE_HOLD) || (mode == MODE_REL_HOLD);
			end
		end else if (btn != BS_RELEASED) begin
			if (phase != PH_RELEASE) begin
				phase      = PH_RELEASE;
				release_t0 = now;
			end else if (since_release > release_delay) begin
				if (btn == BS_PRESSED) begin
					word.press_event = (mode == MODE_RELEASE) || (mode == MODE_REL_HOLD) ||
						(mode == MODE_ALL);
				end else begin
					word.hold_event = (mode == MODE_HOLD_REL) || (mode == MODE_ALL);
				end
				btn   = BS_RELEASED;
				phase = PH_NONE;
			end
		end else if (phase == PH_PRESS) begin
			phase = PH_NONE;
		end
		case (btn)
			BS_PRESSED: word.button_state = CODE_PRESSED;
			BS_HELD:    word.button_state = CODE_HELD;
			default:    word.button_state = CODE_RELEASED;
		endcase
		return word;
	endfunction

	task automatic report(input string what, input res_t want, input res_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$display("%0t: %s: press %0b/%0b hold %0b/%0b state %0d/%0d (expected/actual)",
				$realtime, what, want.press_event, got.press_event, want.hold_event,
				got.hold_event, want.button_state, got.button_state);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode          = MODE_RST;
			press_delay   = DEBOUNCE_RST;
			release_delay = RELEASE_RST;
			hold_delay    = HOLD_RST;
			btn           = BS_RELEASED;
			phase         = PH_NONE;
			press_t0      = '0;
			release_t0    = '0;
			expected_results.delete();
			mismatch_count = 0;
			outstanding   <= 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					REG_TRIGGER_MODE:   mode          = cfg_data[MODE_W-1:0];
					REG_DEBOUNCE_TICKS: press_delay   = cfg_data[DELAY_W-1:0];
					REG_RELEASE_TICKS:  release_delay = cfg_data[DELAY_W-1:0];
					REG_HOLD_TICKS:     hold_delay    = cfg_data[DELAY_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen_word.press_event  = out_press;
				seen_word.hold_event   = out_hold;
				seen_word.button_state = out_state;
				if (expected_results.size() == 0) begin
					report("word with nothing expected", '0, seen_word);
				end else begin
					want_word = expected_results.pop_front();
					if (seen_word != want_word)
						report("word mismatch", want_word, seen_word);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(debounce_poll(in_pin, in_tick));
			outstanding <= expected_results.size();
		end
	end

endmodule

`default_nettype wire

>>> bench/tb_button_debounce_hold_detector.sv
`default_nettype none

module tb_button_debounce_hold_detector;
	import bdhd_pkg::*;

	// Cycles with no word moving on either channel before the run is called hung.
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_POLLS = 1300;
	localparam int SEGMENTS     = 16;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	bdhd_in_if  in_ch();
	bdhd_out_if out_ch();

	int chk_fails;
	int chk_outstanding;

	// Idle percentages for the sender and the receiver; start with a mostly stalled sink.
	int tx_gap_pct = 15;
	int rx_gap_pct = 74;

	// Free-running tick the polls carry, and the delays currently programmed.
	logic [TICK_W-1:0]  tick_now;
	logic [DELAY_W-1:0] cur_deb;
	logic [DELAY_W-1:0] cur_rel;
	logic [DELAY_W-1:0] cur_hold;
	int                 polls_sent;

	button_debounce_hold_detector #(.TIME_WIDTH(TICK_W)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	debounce_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_pin      (in_ch.pin_active),
		.in_tick     (in_ch.now_tick),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_press   (out_ch.press_event),
		.out_hold    (out_ch.hold_event),
		.out_state   (out_ch.button_state),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.fails       (chk_fails),
		.outstanding (chk_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: drop ready at random according to the current idle percentage.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= rx_gap_pct);
		end
	end

	// Watchdog: end the run when nothing has moved for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Offer one poll word, idling first at random, and hold it until it is taken.
	task automatic send_poll(input logic pin, input logic [TICK_W-1:0] tick);
		while ($urandom_range(99) < tx_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.pin_active <= pin;
		in_ch.now_tick   <= tick;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Stop sending and wait until every expected word has come back.
	task automatic drain;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (chk_outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Program all four registers back to back once the block is idle.
	task automatic write_settings(input logic [MODE_W-1:0] m, input logic [DELAY_W-1:0] deb,
		input logic [DELAY_W-1:0] rel, input logic [DELAY_W-1:0] hold);
		drain();
		cfg_wen  <= 1'b1;
		cfg_idx  <= REG_TRIGGER_MODE;
		cfg_data <= CFG_DATA_W'(m);
		@(posedge clk);
		cfg_idx  <= REG_DEBOUNCE_TICKS;
		cfg_data <= CFG_DATA_W'(deb);
		@(posedge clk);
		cfg_idx  <= REG_RELEASE_TICKS;
		cfg_data <= CFG_DATA_W'(rel);
		@(posedge clk);
		cfg_idx  <= REG_HOLD_TICKS;
		cfg_data <= CFG_DATA_W'(hold);
		@(posedge clk);
		cfg_wen  <= 1'b0;
		cur_deb  = deb;
		cur_rel  = rel;
		cur_hold = hold;
	endtask

	// Pick a delay for one segment: zero, all ones, small, moderate or anything.
	function automatic logic [DELAY_W-1:0] pick_delay(input int kind);
		case (kind)
			0:       return '0;
			1:       return '1;
			2:       return DELAY_W'($urandom_range(1, 12));
			3:       return DELAY_W'($urandom_range(13, 600));
			default: return DELAY_W'($urandom());
		endcase
	endfunction

	// Pick a span that lands just short of, on, or past a delay, so the strict compare is hit.
	function automatic logic [TICK_W-1:0] span_near(input logic [DELAY_W-1:0] d);
		case ($urandom_range(5))
			0:       return d >> 1;
			1:       return d;
			2:       return d + 1'b1;
			3:       return d + TICK_W'($urandom_range(1, 8));
			4:       return (d == 0) ? d : d - 1'b1;
			default: return d + (d >> 2) + 1'b1;
		endcase
	endfunction

	// Send a run of polls at one level from tick_now up to exactly tick_now + span.
	// Flip the level of inner polls now and then to model bounce and re-press.
	task automatic poll_run(input logic pin, input logic [TICK_W-1:0] span, input int n,
		input int flip_pct);
		logic [TICK_W-1:0] t0;
		logic              lvl;
		t0 = tick_now;
		send_poll(pin, t0);
		for (int k = 1; k <= n; k++) begin
			tick_now = t0 + TICK_W'((64'(span) * 64'(k)) / 64'(n));
			lvl = pin;
			if (k < n && $urandom_range(99) < flip_pct)
				lvl = ~pin;
			send_poll(lvl, tick_now);
		end
		polls_sent += n + 1;
	endtask

	// One press-and-release with random content: sometimes a bounce, then a press that
	// reaches toward the debounce or hold delay, then a release around its delay.
	task automatic gesture;
		logic [TICK_W-1:0] press_span;
		if ($urandom_range(7) == 0)
			tick_now = $urandom();
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				send_poll(1'b1, tick_now);
				tick_now += TICK_W'($urandom_range(0, 3));
				send_poll(1'b0, tick_now);
				tick_now += TICK_W'($urandom_range(0, 3));
				polls_sent += 2;
			end
		end
		case ($urandom_range(2))
			0:       press_span = span_near(cur_deb);
			1:       press_span = span_near(cur_hold);
			default: press_span = cur_deb + span_near(cur_hold);
		endcase
		poll_run(1'b1, press_span, $urandom_range(2, 8), ($urandom_range(1) ? 10 : 0));
		tick_now += TICK_W'($urandom_range(0, 2));
		poll_run(1'b0, span_near(cur_rel), $urandom_range(2, 6), ($urandom_range(1) ? 20 : 0));
		tick_now += TICK_W'($urandom_range(0, 5));
	endtask

	// A burst of unstructured polls, including big jumps of the tick across the wrap.
	task automatic noise_burst;
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(3))
				0:       tick_now = $urandom();
				1:       tick_now += TICK_W'($urandom_range(0, 2000));
				default: tick_now += TICK_W'($urandom_range(0, 3));
			endcase
			send_poll(1'($urandom_range(1)), tick_now);
			polls_sent++;
		end
	endtask

	initial begin
		logic [MODE_W-1:0] seg_mode;
		int                seg_target;

		// Hold every input at a known value from time zero and assert reset.
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.pin_active = 1'b0;
		in_ch.now_tick   = '0;
		cfg_wen          = 1'b0;
		cfg_idx          = REG_TRIGGER_MODE;
		cfg_data         = '0;
		tick_now         = '0;
		polls_sent       = 0;
		cur_deb          = DEBOUNCE_RST;
		cur_rel          = RELEASE_RST;
		cur_hold         = HOLD_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings (press mode): tick extremes, a cancelled press, the press
		// delay across the wrap on both sides of the strict compare, no hold in press mode,
		// re-press during release debounce, and the release delay on both sides.
		send_poll(1'b0, '0);
		send_poll(1'b0, '1);
		send_poll(1'b1, 32'hFFFF_FFF0);
		send_poll(1'b0, 32'hFFFF_FFF8);
		send_poll(1'b1, 32'hFFFF_FFF0);
		send_poll(1'b1, 32'hFFFF_FFF0 + DEBOUNCE_RST);
		send_poll(1'b1, 32'hFFFF_FFF0 + DEBOUNCE_RST + 1);
		send_poll(1'b1, 32'hFFFF_FFF0 + HOLD_RST + 1);
		send_poll(1'b0, 32'h0000_0100);
		send_poll(1'b1, 32'h0000_0105);
		send_poll(1'b0, 32'h0000_0100 + RELEASE_RST);
		send_poll(1'b0, 32'h0000_0100 + RELEASE_RST + 1);
		send_poll(1'b0, 32'h0000_0200);

		// Directed, hold-release mode: hold reached only past the hold delay, held and active
		// is inert, re-press while release of a held button is pending, then release from held.
		write_settings(MODE_HOLD_REL, DEBOUNCE_RST, RELEASE_RST, HOLD_RST);
		send_poll(1'b1, 32'd1000);
		send_poll(1'b1, 32'd1000 + DEBOUNCE_RST + 1);
		send_poll(1'b1, 32'd1000 + HOLD_RST);
		send_poll(1'b1, 32'd1000 + HOLD_RST + 1);
		send_poll(1'b1, 32'd9000);
		send_poll(1'b0, 32'd9000);
		send_poll(1'b1, 32'd9010);
		send_poll(1'b0, 32'd9000 + RELEASE_RST + 1);
		send_poll(1'b0, 32'd9030);

		// Random segments: each one with its own mode and delays. Scatter the modes over
		// the three idling patterns; first and second segments take the all-zero and
		// all-ones delays.
		for (int s = 0; s < SEGMENTS; s++) begin
			if (s == 6) begin
				tx_gap_pct = 74;
				rx_gap_pct = 15;
			end else if (s == 11) begin
				tx_gap_pct = 0;
				rx_gap_pct = 0;
			end
			seg_mode = MODE_W'((s * 3) % 8);
			if (s < 2)
				write_settings(seg_mode, pick_delay(s), pick_delay(s), pick_delay(s));
			else
				write_settings(seg_mode, pick_delay($urandom_range(2, 4)),
					pick_delay($urandom_range(2, 4)), pick_delay($urandom_range(2, 4)));
			if ($urandom_range(1))
				tick_now = 32'hFFFF_FFFF - TICK_W'($urandom_range(0, 2000));
			else
				tick_now = $urandom();
			seg_target = polls_sent + RANDOM_POLLS / SEGMENTS;
			while (polls_sent < seg_target) begin
				if ($urandom_range(9) < 2)
					noise_burst();
				else
					gesture();
			end
		end

		drain();
		if (chk_fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
